>>> design/rpn_stack_alu_unit_assert.svh
`ifndef RPN_STACK_ALU_UNIT_ASSERT_SVH
`define RPN_STACK_ALU_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RPNSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpnsa: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RPNSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpnsa: next-cycle check failed");

`endif

>>> design/rpnsa_pkg.sv
`default_nettype none

package rpnsa_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CMD_W    = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CNT_W    = $clog2(DATA_W);

   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_PUSH   = 4'd0;
   localparam cmd_type CMD_ADD    = 4'd1;
   localparam cmd_type CMD_SUB    = 4'd2;
   localparam cmd_type CMD_MUL    = 4'd3;
   localparam cmd_type CMD_DIV    = 4'd4;
   localparam cmd_type CMD_GT     = 4'd5;
   localparam cmd_type CMD_LT     = 4'd6;
   localparam cmd_type CMD_GE     = 4'd7;
   localparam cmd_type CMD_LE     = 4'd8;
   localparam cmd_type CMD_EQ     = 4'd9;
   localparam cmd_type CMD_DIVMOD = 4'd10;
   localparam cmd_type CMD_POP    = 4'd11;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_UNDERFLOW = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_DIV_ZERO  = 2'd3;

   typedef struct packed {
      logic start;
      logic op_div;
   } md_req_type;

   typedef struct packed {
      logic     done;
      word_type value;
      word_type rem;
   } md_rsp_type;

   // Combinational operators: add, sub and the signed compares.
   function automatic word_type alu_result(input cmd_type cmd, input word_type l,
                                           input word_type r);
      word_type res;
      res = '0;
      case (cmd)
         CMD_ADD: res = l + r;
         CMD_SUB: res = l - r;
         CMD_GT:  res[0] = ($signed(l) >  $signed(r));
         CMD_LT:  res[0] = ($signed(l) <  $signed(r));
         CMD_GE:  res[0] = ($signed(l) >= $signed(r));
         CMD_LE:  res[0] = ($signed(l) <= $signed(r));
         CMD_EQ:  res[0] = (l == r);
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

>>> design/rpn_stack_alu_unit.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_command, req_operand
// rsp_      out        rsp_valid / rsp_ready   rsp_result_value, rsp_status, rsp_last
//
// One item at a time. Push and stack errors go straight to the output stage;
// pop, add, sub, compares and divide by zero pass through an execute state first;
// mul and div also wait on the shared shift-add / restoring divide unit (one bit
// per cycle); divmod emits two words. Unused command codes give no word.
// Stack entries live in a 2-read, 1-write memory with registered read data.
// Synchronous reset empties the stack; entries are not cleared.
// The next item is taken while the last word waits in the output register.
`default_nettype none

module rpn_stack_alu_unit #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [3:0]          req_command,
   input  wire logic signed [31:0]  req_operand,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_result_value,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_MDWAIT = 5'b00100,
      S_EMIT   = 5'b01000,
      S_WRQ    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   rpnsa_pkg::cmd_type cmd_ff, cmd_in;
   rpnsa_pkg::word_type pend_value_ff, pend_value_in;
   rpnsa_pkg::status_type pend_status_ff, pend_status_in;
   logic pend_last_ff, pend_last_in;
   logic rsp_valid_ff, rsp_valid_in;
   rpnsa_pkg::word_type rsp_value_ff, rsp_value_in;
   rpnsa_pkg::status_type rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic [DEPTH_W-1:0] depth_m1;
   logic [DEPTH_W-1:0] depth_m2;
   logic [ADDR_W-1:0]  addr_top;
   logic [ADDR_W-1:0]  addr_next;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   rpnsa_pkg::word_type wr_data;
   rpnsa_pkg::word_type rd_top;
   rpnsa_pkg::word_type rd_next;
   rpnsa_pkg::word_type alu_res;
   rpnsa_pkg::md_req_type md_req;
   rpnsa_pkg::md_rsp_type md_rsp;
   logic               out_free;

   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign addr_top  = depth_m1[ADDR_W-1:0];
   assign addr_next = depth_m2[ADDR_W-1:0];
   assign alu_res   = rpnsa_pkg::alu_result(cmd_ff, rd_next, rd_top);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   rpnsa_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_top),
      .rd_addr_b (addr_next),
      .rd_data_a (rd_top),
      .rd_data_b (rd_next)
   );

   rpnsa_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .opnd_l (rd_next),
      .opnd_r (rd_top),
      .md_rsp (md_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      cmd_in         = cmd_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = addr_next;
      wr_data        = alu_res;
      md_req         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_command;
               pend_value_in  = '0;
               pend_status_in = rpnsa_pkg::ST_OK;
               pend_last_in   = 1'b1;
               if (req_command == rpnsa_pkg::CMD_PUSH) begin
                  state_in = S_EMIT;
                  if (depth_ff >= DEPTH_W'(STACK_DEPTH)) begin
                     pend_status_in = rpnsa_pkg::ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = depth_ff[ADDR_W-1:0];
                     wr_data       = req_operand;
                     depth_in      = depth_ff + DEPTH_W'(1);
                     pend_value_in = req_operand;
                  end
               end else if (req_command == rpnsa_pkg::CMD_POP) begin
                  if (depth_ff == '0) begin
                     pend_status_in = rpnsa_pkg::ST_UNDERFLOW;
                     state_in       = S_EMIT;
                  end else begin
                     state_in = S_EXEC;
                  end
               end else if (req_command < rpnsa_pkg::CMD_POP) begin
                  if (depth_ff < DEPTH_W'(2)) begin
                     pend_status_in = rpnsa_pkg::ST_UNDERFLOW;
                     state_in       = S_EMIT;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
               // unused codes: drop the word
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
            if (cmd_ff == rpnsa_pkg::CMD_POP) begin
               pend_value_in = rd_top;
               depth_in      = depth_m1;
            end else if ((cmd_ff == rpnsa_pkg::CMD_DIV || cmd_ff == rpnsa_pkg::CMD_DIVMOD)
                         && rd_top == '0) begin
               pend_status_in = rpnsa_pkg::ST_DIV_ZERO;
            end else if (cmd_ff == rpnsa_pkg::CMD_MUL || cmd_ff == rpnsa_pkg::CMD_DIV ||
                         cmd_ff == rpnsa_pkg::CMD_DIVMOD) begin
               md_req.start  = 1'b1;
               md_req.op_div = (cmd_ff != rpnsa_pkg::CMD_MUL);
               state_in      = S_MDWAIT;
            end else begin
               wr_en         = 1'b1;
               depth_in      = depth_m1;
               pend_value_in = alu_res;
            end
         end
         S_MDWAIT: begin
            if (md_rsp.done) begin
               wr_en    = 1'b1;
               state_in = S_EMIT;
               if (cmd_ff == rpnsa_pkg::CMD_DIVMOD) begin
                  // remainder goes below, quotient follows on top
                  wr_data       = md_rsp.rem;
                  pend_value_in = md_rsp.rem;
                  pend_last_in  = 1'b0;
               end else begin
                  wr_data       = md_rsp.value;
                  depth_in      = depth_m1;
                  pend_value_in = md_rsp.value;
               end
            end
         end
         S_WRQ: begin
            wr_en         = 1'b1;
            wr_addr       = addr_top;
            wr_data       = md_rsp.value;
            pend_value_in = md_rsp.value;
            pend_last_in  = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               rsp_last_in   = pend_last_ff;
               state_in      = pend_last_ff ? S_IDLE : S_WRQ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/rpnsa_stack_mem.sv
`default_nettype none

module rpnsa_stack_mem #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire rpnsa_pkg::word_type      wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr_a,
   input  wire logic [ADDR_W-1:0]        rd_addr_b,
   output rpnsa_pkg::word_type           rd_data_a,
   output rpnsa_pkg::word_type           rd_data_b
);

   rpnsa_pkg::word_type mem [DEPTH];
   rpnsa_pkg::word_type rd_a_ff;
   rpnsa_pkg::word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> design/rpnsa_muldiv.sv
`default_nettype none

module rpnsa_muldiv (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rpnsa_pkg::md_req_type md_req,
   input  wire rpnsa_pkg::word_type   opnd_l,
   input  wire rpnsa_pkg::word_type   opnd_r,
   output rpnsa_pkg::md_rsp_type      md_rsp
);

   localparam int unsigned W = rpnsa_pkg::DATA_W;

   logic busy_ff, busy_in;
   logic fix_ff, fix_in;
   logic done_ff, done_in;
   logic is_div_ff, is_div_in;
   logic neg_q_ff, neg_q_in;
   logic neg_r_ff, neg_r_in;
   logic [rpnsa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   rpnsa_pkg::word_type acc_ff, acc_in;
   rpnsa_pkg::word_type sh_ff, sh_in;
   rpnsa_pkg::word_type opd_ff, opd_in;
   rpnsa_pkg::word_type value_ff, value_in;
   rpnsa_pkg::word_type rem_ff, rem_in;

   logic [W:0]          trial;
   rpnsa_pkg::word_type mag_l;
   rpnsa_pkg::word_type mag_r;

   assign trial = {acc_ff, sh_ff[W-1]} - {1'b0, opd_ff};
   assign mag_l = opnd_l[W-1] ? ('0 - opnd_l) : opnd_l;
   assign mag_r = opnd_r[W-1] ? ('0 - opnd_r) : opnd_r;

   always_comb begin
      busy_in   = busy_ff;
      fix_in    = 1'b0;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      sh_in     = sh_ff;
      opd_in    = opd_ff;
      value_in  = value_ff;
      rem_in    = rem_ff;

      if (md_req.start) begin
         busy_in   = 1'b1;
         is_div_in = md_req.op_div;
         cnt_in    = '0;
         acc_in    = '0;
         neg_q_in  = opnd_l[W-1] ^ opnd_r[W-1];
         neg_r_in  = opnd_l[W-1];
         if (md_req.op_div) begin
            sh_in  = mag_l;
            opd_in = mag_r;
         end else begin
            sh_in  = opnd_r;
            opd_in = opnd_l;
         end
      end else if (busy_ff) begin
         if (is_div_ff) begin
            // restoring step: keep the subtraction when it does not borrow
            if (!trial[W]) begin
               acc_in = trial[W-1:0];
               sh_in  = {sh_ff[W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[W-2:0], sh_ff[W-1]};
               sh_in  = {sh_ff[W-2:0], 1'b0};
            end
         end else begin
            if (sh_ff[0]) begin
               acc_in = acc_ff + opd_ff;
            end
            opd_in = {opd_ff[W-2:0], 1'b0};
            sh_in  = {1'b0, sh_ff[W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rpnsa_pkg::CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // apply signs of the truncating divide; a product passes as it is
         done_in = 1'b1;
         if (is_div_ff) begin
            value_in = neg_q_ff ? ('0 - sh_ff) : sh_ff;
            rem_in   = neg_r_ff ? ('0 - acc_ff) : acc_ff;
         end else begin
            value_in = acc_ff;
            rem_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      opd_ff    <= opd_in;
      value_ff  <= value_in;
      rem_ff    <= rem_in;
   end

   assign md_rsp.done  = done_ff;
   assign md_rsp.value = value_ff;
   assign md_rsp.rem   = rem_ff;

endmodule

`default_nettype wire

>>> design/rpnsa_checker.sv
`default_nettype none
`include "rpn_stack_alu_unit_assert.svh"

module rpnsa_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic [1:0]         rsp_status,
   input wire logic               rsp_last
);

   // error words carry a zero value
   `RPNSA_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != rpnsa_pkg::ST_OK), rsp_result_value == '0)

   // an error ends its item
   `RPNSA_ASSERT_SAME(a_err_last, clock, reset, rsp_valid && (rsp_status != rpnsa_pkg::ST_OK), rsp_last)

   // mid-item word: the block is still busy with that item
   `RPNSA_ASSERT_SAME(a_mid_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // hold a stalled word
   `RPNSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_last))

endmodule

bind rpn_stack_alu_unit rpnsa_checker u_rpnsa_checker (.*);

`default_nettype wire
